/* design/btop_pkg.sv */
// Shared types and constants for the binary tile OR pooling block.
package btop_pkg;

  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_H     = 3'd4;

  localparam logic [12:0] RST_IMAGE_COLS = 13'd640;
  localparam logic [8:0]  RST_GRID_W     = 9'd64;
  localparam logic [8:0]  RST_GRID_H     = 9'd48;
  localparam logic [12:0] RST_TILE_W     = 13'd10;
  localparam logic [12:0] RST_TILE_H     = 13'd10;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic       occupied;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic       frame_done;
  } cell_t;

endpackage

/* design/btop_ram.sv */
// Generic single-port-write, registered-read RAM.
module btop_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/binary_tile_or_pool.sv */
// Binary tile OR pooling: raster edge pixels in, one occupancy flag per grid cell out.
//
// Pixels enter on the pix channel in raster order, one transfer per pixel; frame_start
// on a pixel puts all position counters back to the top left before that pixel counts.
// Each grid cell covers tile_w by tile_h pixels. When the bottom right pixel of a cell
// arrives, one cell transfer leaves on the cell channel with the OR of the whole tile.
// Pixels right of or below the grid give nothing.
// The block takes one pixel per clock cycle while pix_stall is low. A cell result is
// registered in the second stage and then in the output queue before it appears on the
// cell outputs. The running OR per grid column sits in a one-bit-wide RAM; each pixel
// reads it at transfer and writes it back in the following cycle, with a bypass when
// the next pixel hits the same column. A three-entry output queue takes results while
// the receiver stalls; pix_stall rises when that queue could overflow or while the
// column RAM is cleared; after reset every entry is cleared with pix_stall high.
// Configuration writes through cfg_write, cfg_index and cfg_data are taken at any time,
// but should be made only while no pixel is in flight.
module binary_tile_or_pool #(
  parameter int MAX_GRID = 256,
  parameter int MAX_DIM  = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  btop_pkg::pix_t                 pix,
  output logic                           cell_valid,
  input  logic                           cell_stall,
  output btop_pkg::cell_t                cell_data,
  input  logic                           cfg_write,
  input  logic [btop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btop_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DW = $clog2(MAX_DIM);
  localparam int EW = DW + 1;
  localparam int GW = $clog2(MAX_GRID + 1);
  localparam int AW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int FIFO_DEPTH = 3;
  localparam logic [1:0] FIFO_LAST = 2'(FIFO_DEPTH - 1);

  logic [12:0] image_cols;
  logic [8:0]  grid_w;
  logic [8:0]  grid_h;
  logic [12:0] tile_w;
  logic [12:0] tile_h;

  logic [EW-1:0] cols_eff, tw_eff, th_eff;
  logic [GW-1:0] gw_eff, gh_eff;

  logic [DW-1:0] pcol, itc, itr;
  logic [GW-1:0] gcol, grow;
  logic [DW-1:0] cur_pcol, cur_itc, cur_itr;
  logic [GW-1:0] cur_gcol, cur_grow;
  logic [DW-1:0] pcol_next, itc_next, itr_next;
  logic [GW-1:0] gcol_next, grow_next;
  logic [EW-1:0] pcol_inc, itc_inc, itr_inc;

  logic accept;
  logic cur_active, cur_first, cur_last, cur_done;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic          s1_valid, s1_active, s1_first, s1_last, s1_edge, s1_done;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_col, s1_row;
  logic          s1_we, s1_bit, s1_old, push;
  logic          fwd_hit, fwd_bit;

  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, rd_addr;

  btop_pkg::cell_t fifo_q [FIFO_DEPTH];
  btop_pkg::cell_t push_cell;
  logic [1:0]      wr_ptr, rd_ptr, fcount;
  logic [2:0]      fill_need;
  logic            pop;

  function automatic logic [EW-1:0] eff_dim(input logic [12:0] v);
    logic [EW-1:0] r;
    if (v == 13'd0) begin
      r = EW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = EW'(MAX_DIM);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic [GW-1:0] eff_grid(input logic [8:0] v);
    logic [GW-1:0] r;
    if (int'(v) > MAX_GRID) begin
      r = GW'(MAX_GRID);
    end else begin
      r = GW'(v);
    end
    return r;
  endfunction

  always_comb begin
    cols_eff = eff_dim(image_cols);
    tw_eff   = eff_dim(tile_w);
    th_eff   = eff_dim(tile_h);
    gw_eff   = eff_grid(grid_w);
    gh_eff   = eff_grid(grid_h);
  end

  assign accept = pix_valid && !pix_stall;

  always_comb begin
    cur_pcol = pix.frame_start ? '0 : pcol;
    cur_itc  = pix.frame_start ? '0 : itc;
    cur_itr  = pix.frame_start ? '0 : itr;
    cur_gcol = pix.frame_start ? '0 : gcol;
    cur_grow = pix.frame_start ? '0 : grow;

    cur_active = (cur_gcol < gw_eff) && (cur_grow < gh_eff);
    cur_first  = (cur_itc == '0) && (cur_itr == '0);
    cur_last   = (EW'(cur_itc) == tw_eff - EW'(1)) && (EW'(cur_itr) == th_eff - EW'(1));
    cur_done   = (cur_gcol == gw_eff - GW'(1)) && (cur_grow == gh_eff - GW'(1));

    pcol_inc = EW'(cur_pcol) + EW'(1);
    itc_inc  = EW'(cur_itc) + EW'(1);
    itr_inc  = EW'(cur_itr) + EW'(1);

    pcol_next = cur_pcol;
    itc_next  = cur_itc;
    itr_next  = cur_itr;
    gcol_next = cur_gcol;
    grow_next = cur_grow;
    if (pcol_inc >= cols_eff) begin
      pcol_next = '0;
      itc_next  = '0;
      gcol_next = '0;
      if (itr_inc >= th_eff) begin
        itr_next = '0;
        if (cur_grow < gh_eff) begin
          grow_next = cur_grow + GW'(1);
        end
      end else begin
        itr_next = itr_inc[DW-1:0];
      end
    end else begin
      pcol_next = pcol_inc[DW-1:0];
      if (itc_inc >= tw_eff) begin
        itc_next = '0;
        if (cur_gcol < gw_eff) begin
          gcol_next = cur_gcol + GW'(1);
        end
      end else begin
        itc_next = itc_inc[DW-1:0];
      end
    end
  end

  assign rd_addr = AW'(cur_gcol);

  always_comb begin
    s1_we  = s1_valid && s1_active;
    s1_old = fwd_hit ? fwd_bit : ram_rdata;
    s1_bit = (!s1_first && s1_old) || s1_edge;
    push   = s1_we && s1_last;

    ram_we    = clr_busy || s1_we;
    ram_waddr = clr_busy ? clr_addr : s1_addr;
    ram_wdata = clr_busy ? 1'b0 : s1_bit;

    push_cell.occupied   = s1_bit;
    push_cell.cell_col   = s1_col;
    push_cell.cell_row   = s1_row;
    push_cell.frame_done = s1_done;

    pop        = (fcount != 2'd0) && !cell_stall;
    fill_need  = 3'(fcount) + 3'(push);
    pix_stall  = clr_busy || (fill_need >= 3'(FIFO_DEPTH));
    cell_valid = (fcount != 2'd0);
    cell_data  = fifo_q[rd_ptr];
  end

  btop_ram #(
    .WIDTH(1),
    .DEPTH(MAX_GRID)
  ) u_col_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= btop_pkg::RST_IMAGE_COLS;
      grid_w     <= btop_pkg::RST_GRID_W;
      grid_h     <= btop_pkg::RST_GRID_H;
      tile_w     <= btop_pkg::RST_TILE_W;
      tile_h     <= btop_pkg::RST_TILE_H;
      pcol       <= '0;
      itc        <= '0;
      itr        <= '0;
      gcol       <= '0;
      grow       <= '0;
      clr_busy   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fcount     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          btop_pkg::REG_IMAGE_COLS: image_cols <= cfg_data;
          btop_pkg::REG_GRID_W:     grid_w     <= cfg_data[8:0];
          btop_pkg::REG_GRID_H:     grid_h     <= cfg_data[8:0];
          btop_pkg::REG_TILE_W:     tile_w     <= cfg_data;
          btop_pkg::REG_TILE_H:     tile_h     <= cfg_data;
          default: ;
        endcase
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_GRID - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        pcol <= pcol_next;
        itc  <= itc_next;
        itr  <= itr_next;
        gcol <= gcol_next;
        grow <= grow_next;
      end
      s1_valid <= accept;
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_LAST) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_LAST) ? 2'd0 : rd_ptr + 2'd1;
      end
      fcount <= 2'(fill_need - 3'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_active <= cur_active;
      s1_first  <= cur_first;
      s1_last   <= cur_last;
      s1_edge   <= (pix.pixel != 8'd0);
      s1_done   <= cur_done;
      s1_addr   <= rd_addr;
      s1_col    <= 8'(cur_gcol);
      s1_row    <= 8'(cur_grow);
      fwd_hit   <= s1_we && (s1_addr == rd_addr);
      fwd_bit   <= s1_bit;
    end
    if (push) begin
      fifo_q[wr_ptr] <= push_cell;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fcount != 2'(FIFO_DEPTH)) || pop)
    else $error("Result queue overflow.");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !accept)
    else $error("Pixel taken while the column RAM is being cleared.");

  a_clear_length: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> $past(clr_addr) == AW'(MAX_GRID - 1))
    else $error("Clearing pass ended early.");

  a_s1_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(accept))
    else $error("Second stage holds a pixel past its read cycle.");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    push && s1_done |-> s1_last && s1_active)
    else $error("Frame done flagged on a pixel that does not finish a cell.");
`endif

endmodule

/* verif/binary_tile_or_pool_tb.sv */
// Self-checking testbench for binary_tile_or_pool: raster pixel frames in, OR-pooled cells checked.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          RANDOM_ITEMS  = 300;
  localparam int          PRINT_LIMIT   = 100;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           pix_valid = 1'b0;
  logic                           pix_stall;
  btop_pkg::pix_t                 pix = '0;
  logic                           cell_valid;
  logic                           cell_stall = 1'b0;
  btop_pkg::cell_t                cell_data;
  logic                           cfg_write = 1'b0;
  logic [btop_pkg::CFG_IDX_W-1:0] cfg_index = btop_pkg::REG_IMAGE_COLS;
  logic [btop_pkg::CFG_W-1:0]     cfg_data = '0;

  btop_pkg::pix_t  pix_queue[$];
  btop_pkg::cell_t cell_expect[$];
  btop_pkg::cell_t cell_want;
  bit              pix_taken = 1'b0;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  int              hold_left = 0;
  int              errors = 0;
  int unsigned     cycle_count = 0;

  // Predictor copy of the configuration and the raster position state.
  logic [12:0] cur_image_cols = btop_pkg::RST_IMAGE_COLS;
  logic [8:0]  cur_grid_w = btop_pkg::RST_GRID_W;
  logic [8:0]  cur_grid_h = btop_pkg::RST_GRID_H;
  logic [12:0] cur_tile_w = btop_pkg::RST_TILE_W;
  logic [12:0] cur_tile_h = btop_pkg::RST_TILE_H;
  logic [11:0] px_col = '0;
  logic [11:0] px_row = '0;
  logic [11:0] tile_col = '0;
  logic [11:0] tile_row = '0;
  logic [8:0]  grid_col = '0;
  logic [8:0]  grid_row = '0;
  bit          col_or [256];

  binary_tile_or_pool dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_data (cell_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return int'(v);
  endfunction

  function automatic int unsigned clamp_grid(input logic [8:0] v);
    if (v > 9'd256) return 256;
    return int'(v);
  endfunction

  task automatic pool_pixel(input btop_pkg::pix_t p);
    int unsigned     cols, tw, th, gw, gh;
    bit              first;
    btop_pkg::cell_t c;
    cols = clamp_dim(cur_image_cols);
    tw = clamp_dim(cur_tile_w);
    th = clamp_dim(cur_tile_h);
    gw = clamp_grid(cur_grid_w);
    gh = clamp_grid(cur_grid_h);
    if (p.frame_start) begin
      px_col = '0;
      px_row = '0;
      tile_col = '0;
      tile_row = '0;
      grid_col = '0;
      grid_row = '0;
    end
    if (grid_col < gw && grid_row < gh) begin
      first = (tile_col == 12'd0 && tile_row == 12'd0);
      col_or[grid_col] = (first ? 1'b0 : col_or[grid_col]) | (p.pixel != 8'd0);
      if (tile_col == tw - 1 && tile_row == th - 1) begin
        c.occupied = col_or[grid_col];
        c.cell_col = grid_col[7:0];
        c.cell_row = grid_row[7:0];
        c.frame_done = (grid_col == gw - 1 && grid_row == gh - 1);
        cell_expect.insert(cell_expect.size(), c);
      end
    end
    if (px_col + 32'd1 >= cols) begin
      px_col = '0;
      tile_col = '0;
      grid_col = '0;
      px_row = px_row + 1'b1;
      if (tile_row + 32'd1 >= th) begin
        tile_row = '0;
        if (grid_row < gh) grid_row = grid_row + 1'b1;
      end else begin
        tile_row = tile_row + 1'b1;
      end
    end else begin
      px_col = px_col + 1'b1;
      if (tile_col + 32'd1 >= tw) begin
        tile_col = '0;
        if (grid_col < gw) grid_col = grid_col + 1'b1;
      end else begin
        tile_col = tile_col + 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (errors < PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d (cell %0d,%0d)", name, got, want,
                                cell_want.cell_col, cell_want.cell_row));
    end
  endtask

  // Sender: a held item stays put until its transfer.
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_taken) begin
      if (pix_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        pix <= pix_queue.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off counted here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      cell_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      cell_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_taken = 1'b0;
    end else begin
      pix_taken = pix_valid && !pix_stall;
      if (pix_taken) pool_pixel(pix);
      if (cell_valid && !cell_stall) begin
        if (cell_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected cell transfer at cell %0d,%0d",
                                    cell_data.cell_col, cell_data.cell_row));
        end else begin
          cell_want = cell_expect.pop_front();
          check_field("occupied", 8'(cell_data.occupied), 8'(cell_want.occupied));
          check_field("cell_col", cell_data.cell_col, cell_want.cell_col);
          check_field("cell_row", cell_data.cell_row, cell_want.cell_row);
          check_field("frame_done", 8'(cell_data.frame_done), 8'(cell_want.frame_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_e m);
    unique case (m)
      IDLE_NONE: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      IDLE_TX: begin
        tx_idle_pct = 78;
        rx_stall_pct = 0;
      end
      IDLE_RX: begin
        tx_idle_pct = 0;
        rx_stall_pct = 78;
      end
      default: begin
        tx_idle_pct = 35;
        rx_stall_pct = 35;
      end
    endcase
  endtask

  task automatic write_reg(input logic [btop_pkg::CFG_IDX_W-1:0] idx,
                           input logic [btop_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    unique case (idx)
      btop_pkg::REG_IMAGE_COLS: cur_image_cols = val;
      btop_pkg::REG_GRID_W:     cur_grid_w = val[8:0];
      btop_pkg::REG_GRID_H:     cur_grid_h = val[8:0];
      btop_pkg::REG_TILE_W:     cur_tile_w = val;
      btop_pkg::REG_TILE_H:     cur_tile_h = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [12:0] cols, gw, gh, tw, th);
    write_reg(btop_pkg::REG_IMAGE_COLS, cols);
    write_reg(btop_pkg::REG_GRID_W, gw);
    write_reg(btop_pkg::REG_GRID_H, gh);
    write_reg(btop_pkg::REG_TILE_W, tw);
    write_reg(btop_pkg::REG_TILE_H, th);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every pending pixel is sent and every expected cell has arrived, or until DRAIN_LIMIT runs out.
  task automatic wait_idle();
    int n;
    n = 0;
    while ((pix_queue.size() != 0 || pix_valid || cell_expect.size() != 0) && n < DRAIN_LIMIT)
    begin
      @(negedge clk);
      n++;
    end
    if (cell_expect.size() != 0) begin
      report_mismatch($sformatf("%0d expected cells never arrived", cell_expect.size()));
      cell_expect.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_px(input logic [7:0] v, input logic fs);
    btop_pkg::pix_t p;
    p.pixel = v;
    p.frame_start = fs;
    pix_queue.insert(pix_queue.size(), p);
  endtask

  function automatic logic [7:0] rand_pixel(input int zero_pct);
    if ($urandom_range(99) < zero_pct) return 8'd0;
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic push_frame(input int unsigned len, input int zero_pct, input int noise_pm);
    for (int unsigned i = 0; i < len; i++) begin
      push_px(rand_pixel(zero_pct), i == 0 || $urandom_range(999) < noise_pm);
    end
  endtask

  initial begin
    int unsigned cols, gw, gh, tw, th, gcols, rows, len;
    int          phase, zero_pct, rand_items;
    int          n_frames;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Two tiles across one tile row, a spare column on the right and a row below the grid.
    set_idling(IDLE_NONE);
    apply_cfg(5, 2, 1, 2, 2);
    push_px(8'd255, 1'b1); push_px(8'd0, 1'b0); push_px(8'd0, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd7, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd0, 1'b0); push_px(8'd0, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd9, 1'b0);
    push_px(8'd128, 1'b0); push_px(8'd1, 1'b0); push_px(8'd2, 1'b0);
    push_px(8'd4, 1'b0);   push_px(8'd16, 1'b0);
    // A new frame must overwrite the stale OR bits on each tile's first pixel.
    push_px(8'd0, 1'b1);   push_px(8'd0, 1'b0); push_px(8'd1, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd0, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd0, 1'b0); push_px(8'd0, 1'b0);
    push_px(8'd0, 1'b0);   push_px(8'd0, 1'b0);
    wait_idle();

    // One-pixel tiles with the receiver held off so the block backs up its input.
    apply_cfg(16, 16, 4, 1, 1);
    hold_left = 300;
    push_frame(64, 50, 0);
    wait_idle();

    set_idling(IDLE_BOTH);
    apply_cfg(0, 3, 2, 0, 0);
    push_frame(6, 50, 0);
    wait_idle();

    apply_cfg(4, 0, 2, 1, 1);
    push_frame(8, 0, 0);
    wait_idle();

    set_idling(IDLE_RX);
    apply_cfg(8191, 8191, 2, 1, 1);
    push_frame(100, 60, 0);
    wait_idle();

    set_idling(IDLE_TX);
    apply_cfg(1, 1, 256, 1, 1);
    push_frame(260, 60, 0);
    wait_idle();

    set_idling(IDLE_NONE);
    apply_cfg(6, 2, 2, 8191, 4096);
    push_frame(24, 50, 0);
    wait_idle();

    phase = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      tw = $urandom_range(6, 1);
      th = $urandom_range(4, 1);
      gcols = $urandom_range(4, 1);
      cols = tw * gcols + $urandom_range(2, 0);
      gw = gcols;
      if ($urandom_range(4) == 0) gw = $urandom_range(gcols + 1, 0);
      gh = $urandom_range(4, 1);
      rows = gh * th + $urandom_range(1, 0);
      if ($urandom_range(9) == 0) begin
        tw = 0;
        cols = gw;
      end
      if ($urandom_range(9) == 0) begin
        th = 0;
        rows = gh;
      end
      zero_pct = ($urandom_range(2) == 0) ? 60 : 96;
      set_idling(idle_mode_e'(phase % 4));
      apply_cfg(13'(cols), 13'(gw), 13'(gh), 13'(tw), 13'(th));
      n_frames = $urandom_range(2, 1);
      for (int f = 0; f < n_frames; f++) begin
        len = (cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows);
        if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
        push_frame(len, zero_pct, 5);
        rand_items += len;
      end
      wait_idle();
      phase++;
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
